/* hdl/q4da_pkg.sv */
// shared constants, types and fp32 helper functions of the q4 dot argmax block
package q4da_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_HIDDEN = 4096;
  localparam int TOKEN_BITS = 20;
  localparam int BLOCK_SIZE = 32;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ELEM_W    = $clog2(MAX_HIDDEN);
  localparam int ADDR_W    = ROW_W + ELEM_W;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_HIDDEN;
  localparam int STEP_W    = $clog2(BLOCK_SIZE);

  localparam int ACT_W      = 2;
  localparam int IN_ROW_W   = 3;
  localparam int IN_ELEM_W  = 12;
  localparam int TOK_W      = 20;
  localparam int BLK_W      = 7;
  localparam int NROWS_W    = 4;
  localparam int NBLK_W     = 8;
  localparam int CFG_W      = 8;
  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 56;

  localparam int MW = 50;

  localparam logic [31:0] NEG_INF   = 32'hFF80_0000;
  localparam logic [31:0] DEF_NAN   = 32'hFFC0_0000;
  localparam logic [31:0] QNAN_BIT  = 32'h0040_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
  localparam logic [TOKEN_BITS-1:0] TOKEN_ONES = '1;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BLOCK  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } q4da_act_e;

  typedef enum logic [0:0] {
    CFG_ROWS   = 1'b0,
    CFG_BLOCKS = 1'b1
  } q4da_cfg_e;

  typedef enum logic [1:0] {
    FS_MUL_W     = 2'd0,
    FS_ADD_DOT   = 2'd1,
    FS_MUL_SCALE = 2'd2,
    FS_ADD_ACC   = 2'd3
  } q4da_fsel_e;

  typedef enum logic [0:0] {
    FOP_MUL = 1'b0,
    FOP_ADD = 1'b1
  } q4da_fop_e;

  typedef struct packed {
    logic              take;
    logic              rd_en;
    logic              fstart;
    q4da_fsel_e        fsel;
    logic              dot_wr;
    logic              acc_wr;
    logic              close;
    logic              out_load;
    logic              clr_best;
    logic [ROW_W-1:0]  row;
    logic [STEP_W-1:0] step;
  } q4da_cmd_t;

  typedef struct packed {
    logic             fpu_done;
    logic             blk_ok;
    logic             in_last;
    logic             last_q;
    logic             out_free;
    logic [ROW_W-1:0] n_last;
  } q4da_sts_t;

  // unrounded value: m * 2^(x - (MW-1)), or a finished special pattern
  typedef struct packed {
    logic               spec;
    logic [31:0]        sbits;
    logic               sgn;
    logic signed [10:0] x;
    logic [MW-1:0]      m;
  } q4da_unr_t;

  function automatic logic signed [10:0] fp_exp(input logic [7:0] e);
    logic signed [10:0] x;
    x = (e == 8'd0) ? 11'sd1 : $signed({3'b000, e});
    return x - 11'sd127;
  endfunction

  function automatic logic [23:0] fp_sig(input logic [31:0] f);
    return {f[30:23] != 8'd0, f[22:0]};
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  function automatic q4da_unr_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
    q4da_unr_t u;
    logic [47:0] prod;
    u = '0;
    prod = 48'(fp_sig(a)) * 48'(fp_sig(b));
    if (fp_is_nan(a)) begin
      u.spec  = 1'b1;
      u.sbits = a | QNAN_BIT;
    end else if (fp_is_nan(b)) begin
      u.spec  = 1'b1;
      u.sbits = b | QNAN_BIT;
    end else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_inf(b) && fp_is_zero(a))) begin
      u.spec  = 1'b1;
      u.sbits = DEF_NAN;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      u.spec  = 1'b1;
      u.sbits = {a[31] ^ b[31], INF_MAG};
    end else begin
      u.sgn = a[31] ^ b[31];
      u.x   = fp_exp(a[30:23]) + fp_exp(b[30:23]) + 11'sd1;
      u.m   = {prod, 2'b00};
    end
    return u;
  endfunction

  function automatic q4da_unr_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
    q4da_unr_t u;
    logic big_is_b;
    logic [31:0] bg;
    logic [31:0] sm;
    logic signed [10:0] xb;
    logic signed [10:0] xs;
    logic [10:0] d;
    logic [MW-1:0] eb;
    logic [MW-1:0] es;
    logic [MW-1:0] mask;
    logic sticky;
    u = '0;
    big_is_b = fp_exp(b[30:23]) > fp_exp(a[30:23]);
    bg = big_is_b ? b : a;
    sm = big_is_b ? a : b;
    xb = fp_exp(bg[30:23]);
    xs = fp_exp(sm[30:23]);
    d  = 11'(xb - xs);
    eb = {1'b0, fp_sig(bg), 25'b0};
    es = {1'b0, fp_sig(sm), 25'b0};
    if (d >= 11'(MW)) begin
      sticky = |es;
      es     = '0;
      es[0]  = sticky;
    end else begin
      mask   = (MW'(1) << d) - MW'(1);
      sticky = |(es & mask);
      es     = es >> d;
      es[0]  = es[0] | sticky;
    end
    if (fp_is_nan(a)) begin
      u.spec  = 1'b1;
      u.sbits = a | QNAN_BIT;
    end else if (fp_is_nan(b)) begin
      u.spec  = 1'b1;
      u.sbits = b | QNAN_BIT;
    end else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
      u.spec  = 1'b1;
      u.sbits = DEF_NAN;
    end else if (fp_is_inf(a)) begin
      u.spec  = 1'b1;
      u.sbits = a;
    end else if (fp_is_inf(b)) begin
      u.spec  = 1'b1;
      u.sbits = b;
    end else begin
      u.x = xb + 11'sd1;
      if (bg[31] == sm[31]) begin
        u.m   = eb + es;
        u.sgn = bg[31];
      end else if (eb >= es) begin
        u.m   = eb - es;
        u.sgn = bg[31];
      end else begin
        u.m   = es - eb;
        u.sgn = sm[31];
      end
      if (u.m == '0) begin
        u.sgn = a[31] & b[31];
      end
    end
    return u;
  endfunction

  function automatic q4da_unr_t fp_norm(input q4da_unr_t u);
    q4da_unr_t r;
    logic [5:0] pos;
    logic [5:0] lz;
    r   = u;
    pos = '0;
    for (int j = 0; j < MW; j++) begin
      if (u.m[j]) pos = 6'(j);
    end
    lz = 6'(MW - 1) - pos;
    if (!u.spec) begin
      if (u.m == '0) begin
        r.spec  = 1'b1;
        r.sbits = {u.sgn, 31'd0};
      end else begin
        r.m = u.m << lz;
        r.x = u.x - $signed({5'b00000, lz});
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_round(input q4da_unr_t u);
    logic signed [10:0] e;
    logic [10:0] sh;
    logic [MW-1:0] mm;
    logic [MW-1:0] mask;
    logic st;
    logic g;
    logic inc;
    logic [24:0] mr;
    logic [31:0] t;
    e  = u.x + 11'sd127;
    mm = u.m;
    if (e < 11'sd1) begin
      sh = 11'(11'sd1 - e);
      if (sh > 11'(MW)) sh = 11'(MW);
      mask  = (MW'(1) << sh) - MW'(1);
      st    = |(u.m & mask);
      mm    = u.m >> sh;
      mm[0] = mm[0] | st;
      e     = 11'sd1;
    end
    g   = mm[MW-25];
    st  = |mm[MW-26:0];
    inc = g & (st | mm[MW-24]);
    mr  = {1'b0, mm[MW-1:MW-24]} + 25'(inc);
    t   = (32'(unsigned'(11'(e - 11'sd1))) << 23) + 32'(mr);
    if (t >= {1'b0, INF_MAG}) t = {1'b0, INF_MAG};
    if (u.spec) return u.sbits;
    return {u.sgn, t[30:0]};
  endfunction

  function automatic logic [31:0] half_to_fp32(input logic [15:0] h);
    logic s;
    logic [4:0] e;
    logic [9:0] m;
    logic [9:0] mm;
    logic [3:0] pos;
    logic [3:0] sh;
    logic [31:0] r;
    s   = h[15];
    e   = h[14:10];
    m   = h[9:0];
    pos = '0;
    for (int j = 0; j < 10; j++) begin
      if (m[j]) pos = 4'(j);
    end
    sh = 4'd10 - pos;
    mm = m << sh;
    if (e == 5'd0) begin
      if (m == 10'd0) r = {s, 31'd0};
      else r = {s, 8'd103 + {4'b0000, pos}, mm, 13'd0};
    end else if (e == 5'd31) begin
      r = {s, 8'hFF, m, 13'd0};
    end else begin
      r = {s, 8'd112 + {3'b000, e}, m, 13'd0};
    end
    return r;
  endfunction

  // code nibble minus eight as fp32
  function automatic logic [31:0] weight_fp(input logic [3:0] nib);
    logic [3:0] mag;
    logic [31:0] r;
    mag = nib[3] ? {1'b0, nib[2:0]} : 4'd8 - nib;
    case (mag)
      4'd1:    r = 32'h3F80_0000;
      4'd2:    r = 32'h4000_0000;
      4'd3:    r = 32'h4040_0000;
      4'd4:    r = 32'h4080_0000;
      4'd5:    r = 32'h40A0_0000;
      4'd6:    r = 32'h40C0_0000;
      4'd7:    r = 32'h40E0_0000;
      4'd8:    r = 32'h4100_0000;
      default: r = 32'd0;
    endcase
    r[31] = ~nib[3];
    return r;
  endfunction

  function automatic logic [31:0] fp_key(input logic [31:0] f);
    return f[31] ? ~f : (f | 32'h8000_0000);
  endfunction

  function automatic logic fp_better(input logic [31:0] v, input logic [31:0] b,
                                     input logic [TOKEN_BITS-1:0] tok,
                                     input logic [TOKEN_BITS-1:0] btok);
    logic zz;
    logic gt;
    logic eq;
    zz = fp_is_zero(v) && fp_is_zero(b);
    gt = !zz && (fp_key(v) > fp_key(b));
    eq = zz || (v == b);
    return !fp_is_nan(v) && !fp_is_nan(b) && (gt || (eq && (tok < btok)));
  endfunction

endpackage

/* hdl/q4da_fpu.sv */
// shared fp32 multiply/add unit: registered operand decode, normalize and round
module q4da_fpu (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  q4da_pkg::q4da_fop_e  op_i,
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  output logic                 done_o,
  output logic [31:0]          res_o
);
  import q4da_pkg::*;

  q4da_unr_t pre_d;
  q4da_unr_t st1_q;
  q4da_unr_t st2_q;
  logic [31:0] res_q;
  logic v1_q, v2_q, v3_q;

  always_comb begin
    if (op_i == FOP_MUL) pre_d = fp_mul_pre(a_i, b_i);
    else pre_d = fp_add_pre(a_i, b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) st1_q <= pre_d;
    if (v1_q) st2_q <= fp_norm(st1_q);
    if (v2_q) res_q <= fp_round(st2_q);
  end

  assign done_o = v3_q;
  assign res_o  = res_q;

endmodule

/* hdl/q4da_dp.sv */
// datapath: hidden store, block registers, row accumulators, bests, result register
module q4da_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_addr_i,
  input  logic [q4da_pkg::CFG_W-1:0]         cfg_data_i,
  input  q4da_pkg::q4da_act_e                action_i,
  input  logic [q4da_pkg::IN_ROW_W-1:0]      row_select_i,
  input  logic [q4da_pkg::IN_ELEM_W-1:0]     element_index_i,
  input  logic [31:0]                        hidden_value_i,
  input  logic [q4da_pkg::TOK_W-1:0]         token_i,
  input  logic [q4da_pkg::BLK_W-1:0]         block_index_i,
  input  logic [15:0]                        scale_half_i,
  input  logic [63:0]                        codes_low_i,
  input  logic [63:0]                        codes_high_i,
  input  logic                               last_block_i,
  input  q4da_pkg::q4da_cmd_t                cmd_i,
  output q4da_pkg::q4da_sts_t                sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [q4da_pkg::IN_ROW_W-1:0]      out_row_o,
  output logic [q4da_pkg::TOK_W-1:0]         best_token_o,
  output logic [31:0]                        best_logit_o,
  output logic                               last_row_o
);
  import q4da_pkg::*;

  logic [NROWS_W-1:0] rows_q;
  logic [NBLK_W-1:0]  blocks_q;
  logic [NROWS_W-1:0] nr;
  logic [ROW_W-1:0]   n_last;

  logic [31:0] mem_q [MEM_DEPTH];
  logic [31:0] rdata_q;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [STEP_W-1:0] off;
  logic wr_en;

  logic [TOKEN_BITS-1:0] tok_q;
  logic [BLK_W-1:0]      blk_q;
  logic [31:0]           scale_q;
  logic [127:0]          codes_q;
  logic                  last_q;

  logic [31:0]           dot_q;
  logic [31:0]           acc_q      [MAX_ROWS];
  logic [31:0]           best_lg_q  [MAX_ROWS];
  logic [TOKEN_BITS-1:0] best_tk_q  [MAX_ROWS];

  logic                  out_valid_q;
  logic [IN_ROW_W-1:0]   out_row_q;
  logic [TOK_W-1:0]      out_tok_q;
  logic [31:0]           out_lg_q;
  logic                  out_last_q;

  logic [7:0]  code_byte;
  logic [3:0]  nib;
  logic [31:0] fa, fb;
  q4da_fop_e   fop;
  logic        fdone;
  logic [31:0] fres;

  // active row count, zero acts as one, values above MAX_ROWS act as MAX_ROWS
  always_comb begin
    if (rows_q == '0) nr = NROWS_W'(1);
    else if (int'(rows_q) > MAX_ROWS) nr = NROWS_W'(MAX_ROWS);
    else nr = rows_q;
    n_last = ROW_W'(nr - NROWS_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= NROWS_W'(1);
      blocks_q <= NBLK_W'(1);
    end else if (cfg_we_i) begin
      case (q4da_cfg_e'(cfg_addr_i))
        CFG_ROWS:   rows_q   <= cfg_data_i[NROWS_W-1:0];
        CFG_BLOCKS: blocks_q <= cfg_data_i[NBLK_W-1:0];
        default:    ;
      endcase
    end
  end

  // element order 0, 16, 1, 17, ...
  assign off   = {cmd_i.step[0], cmd_i.step[STEP_W-1:1]};
  assign wr_en = cmd_i.take && (action_i == ACT_LOAD) && (int'(row_select_i) < MAX_ROWS);
  assign waddr = {ROW_W'(row_select_i), ELEM_W'(element_index_i)};
  assign raddr = {cmd_i.row, ELEM_W'({blk_q, off})};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= hidden_value_i;
    if (cmd_i.rd_en) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (action_i == ACT_BLOCK)) begin
      tok_q   <= TOKEN_BITS'(token_i);
      blk_q   <= block_index_i;
      scale_q <= half_to_fp32(scale_half_i);
      codes_q <= {codes_high_i, codes_low_i};
    end
    if (cmd_i.dot_wr) dot_q <= fres;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) last_q <= 1'b0;
    else if (cmd_i.take && (action_i == ACT_BLOCK)) last_q <= last_block_i;
  end

  assign code_byte = codes_q[8*cmd_i.step[STEP_W-1:1] +: 8];
  assign nib       = cmd_i.step[0] ? code_byte[7:4] : code_byte[3:0];

  always_comb begin
    case (cmd_i.fsel)
      FS_MUL_W: begin
        fa = weight_fp(nib);
        fb = rdata_q;
      end
      FS_ADD_DOT: begin
        fa = (cmd_i.step == '0) ? 32'd0 : dot_q;
        fb = fres;
      end
      FS_MUL_SCALE: begin
        fa = scale_q;
        fb = dot_q;
      end
      FS_ADD_ACC: begin
        fa = acc_q[cmd_i.row];
        fb = fres;
      end
      default: begin
        fa = 32'd0;
        fb = 32'd0;
      end
    endcase
    fop = ((cmd_i.fsel == FS_MUL_W) || (cmd_i.fsel == FS_MUL_SCALE)) ? FOP_MUL : FOP_ADD;
  end

  q4da_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.fstart),
    .op_i    (fop),
    .a_i     (fa),
    .b_i     (fb),
    .done_o  (fdone),
    .res_o   (fres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        acc_q[r]     <= 32'd0;
        best_lg_q[r] <= NEG_INF;
        best_tk_q[r] <= TOKEN_ONES;
      end
    end else begin
      if (cmd_i.acc_wr) acc_q[cmd_i.row] <= fres;
      if (cmd_i.close) begin
        if (fp_better(acc_q[cmd_i.row], best_lg_q[cmd_i.row], tok_q,
                      best_tk_q[cmd_i.row])) begin
          best_lg_q[cmd_i.row] <= acc_q[cmd_i.row];
          best_tk_q[cmd_i.row] <= tok_q;
        end
        acc_q[cmd_i.row] <= 32'd0;
      end
      if (cmd_i.clr_best) begin
        for (int r = 0; r < MAX_ROWS; r++) begin
          best_lg_q[r] <= NEG_INF;
          best_tk_q[r] <= TOKEN_ONES;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q  <= IN_ROW_W'(cmd_i.row);
      out_tok_q  <= TOK_W'(best_tk_q[cmd_i.row]);
      out_lg_q   <= best_lg_q[cmd_i.row];
      out_last_q <= (cmd_i.row == n_last);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign best_token_o = out_tok_q;
  assign best_logit_o = out_lg_q;
  assign last_row_o   = out_last_q;

  always_comb begin
    sts_o          = '0;
    sts_o.fpu_done = fdone;
    sts_o.blk_ok   = {1'b0, block_index_i} < blocks_q;
    sts_o.in_last  = last_block_i;
    sts_o.last_q   = last_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
    sts_o.n_last   = n_last;
  end

endmodule

/* hdl/q4da_ctrl.sv */
// controller: sequences rows and elements of a block, token close and result beats
module q4da_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  q4da_pkg::q4da_act_e  action_i,
  input  q4da_pkg::q4da_sts_t  sts_i,
  output logic                 in_ready_o,
  output q4da_pkg::q4da_cmd_t  cmd_o
);
  import q4da_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_RD    = 12'b0000_0000_0010,
    ST_MGO   = 12'b0000_0000_0100,
    ST_MWT   = 12'b0000_0000_1000,
    ST_AGO   = 12'b0000_0001_0000,
    ST_AWT   = 12'b0000_0010_0000,
    ST_SGO   = 12'b0000_0100_0000,
    ST_SWT   = 12'b0000_1000_0000,
    ST_CGO   = 12'b0001_0000_0000,
    ST_CWT   = 12'b0010_0000_0000,
    ST_CLOSE = 12'b0100_0000_0000,
    ST_EMIT  = 12'b1000_0000_0000
  } q4da_state_e;

  q4da_state_e state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic row_end;

  assign row_end    = (row_q == sts_i.n_last);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    step_d       = step_q;
    cmd_o        = '0;
    cmd_o.fsel   = FS_MUL_W;
    cmd_o.row    = row_q;
    cmd_o.step   = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          row_d      = '0;
          step_d     = '0;
          case (action_i)
            ACT_BLOCK: begin
              if (sts_i.blk_ok) state_d = ST_RD;
              else if (sts_i.in_last) state_d = ST_CLOSE;
            end
            ACT_FINISH: state_d = ST_EMIT;
            default:    ;
          endcase
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_MGO;
      end
      ST_MGO: begin
        cmd_o.fstart = 1'b1;
        cmd_o.fsel   = FS_MUL_W;
        state_d      = ST_MWT;
      end
      ST_MWT: begin
        if (sts_i.fpu_done) state_d = ST_AGO;
      end
      ST_AGO: begin
        cmd_o.fstart = 1'b1;
        cmd_o.fsel   = FS_ADD_DOT;
        state_d      = ST_AWT;
      end
      ST_AWT: begin
        if (sts_i.fpu_done) begin
          cmd_o.dot_wr = 1'b1;
          if (step_q == '1) begin
            state_d = ST_SGO;
          end else begin
            step_d  = step_q + STEP_W'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_SGO: begin
        cmd_o.fstart = 1'b1;
        cmd_o.fsel   = FS_MUL_SCALE;
        state_d      = ST_SWT;
      end
      ST_SWT: begin
        if (sts_i.fpu_done) state_d = ST_CGO;
      end
      ST_CGO: begin
        cmd_o.fstart = 1'b1;
        cmd_o.fsel   = FS_ADD_ACC;
        state_d      = ST_CWT;
      end
      ST_CWT: begin
        cmd_o.fsel = FS_ADD_ACC;
        if (sts_i.fpu_done) begin
          cmd_o.acc_wr = 1'b1;
          step_d       = '0;
          if (row_end) begin
            row_d   = '0;
            state_d = sts_i.last_q ? ST_CLOSE : ST_IDLE;
          end else begin
            row_d   = row_q + ROW_W'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        if (row_end) state_d = ST_IDLE;
        else row_d = row_q + ROW_W'(1);
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (row_end) begin
            cmd_o.clr_best = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      step_q  <= step_d;
    end
  end

endmodule

/* hdl/q4_block_dot_argmax.sv */
// top level of the q4 quantized block dot product with per-row argmax
// A load beat writes one fp32 hidden element and the input stays ready. A weight block whose
// index is inside the hidden length is run for each row in use: each of the 32 elements needs
// a store read, a multiply and an add through one shared fp32 unit, then the scale multiply
// and accumulator add follow. A last block then compares each row's sum with its best, and a
// block outside the hidden length with last set does only that compare. A finish beat sends
// one result beat per row in use, one per cycle when the output is taken. The hidden store
// has no reset and must be loaded before it is read.
module q4_block_dot_argmax (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_addr_i,
  input  logic [q4da_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // row_select, element_index, hidden_value, token, block_index, scale_half,
  // codes_low, codes_high, zero fill
  input  logic [q4da_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action
  input  logic [q4da_pkg::ACT_W-1:0]          s_axis_tuser_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // out_row, best_token, best_logit, zero fill
  output logic [q4da_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);
  import q4da_pkg::*;

  q4da_cmd_t cmd;
  q4da_sts_t sts;
  q4da_act_e action;
  logic [IN_ROW_W-1:0] out_row;
  logic [TOK_W-1:0]    best_token;
  logic [31:0]         best_logit;

  assign action = q4da_act_e'(s_axis_tuser_i);

  q4da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .action_i   (action),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  q4da_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action),
    .row_select_i    (s_axis_tdata_i[2:0]),
    .element_index_i (s_axis_tdata_i[14:3]),
    .hidden_value_i  (s_axis_tdata_i[46:15]),
    .token_i         (s_axis_tdata_i[66:47]),
    .block_index_i   (s_axis_tdata_i[73:67]),
    .scale_half_i    (s_axis_tdata_i[89:74]),
    .codes_low_i     (s_axis_tdata_i[153:90]),
    .codes_high_i    (s_axis_tdata_i[217:154]),
    .last_block_i    (s_axis_tlast_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_row_o       (out_row),
    .best_token_o    (best_token),
    .best_logit_o    (best_logit),
    .last_row_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, best_logit, best_token, out_row};

endmodule

/* hdl/q4da_chk.sv */
// port-level checker for the q4 dot argmax block, bound to the top level
module q4da_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [0:0]                          cfg_addr_i,
  input logic [q4da_pkg::CFG_W-1:0]          cfg_data_i,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic [q4da_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input logic [q4da_pkg::ACT_W-1:0]          s_axis_tuser_i,
  input logic                                s_axis_tlast_i,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [q4da_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input logic                                m_axis_tlast_o
);
  import q4da_pkg::*;

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i == ACT_FINISH) |=> !s_axis_tready_o)
    else $error("input taken while finish results are sent");

  a_top_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] == 3'(MAX_ROWS - 1)) |-> m_axis_tlast_o)
    else $error("highest row not marked last");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i != ACT_FINISH) |=> !$rose(m_axis_tvalid_o))
    else $error("result beat without finish");

endmodule

bind q4_block_dot_argmax q4da_chk u_q4da_chk (.*);
